@@ hdl/mlr_pkg.sv @@
// Shared types and constants for the midpoint line rasteriser.
// Used by mlr_front, mlr_cmdq, mlr_back and midpoint_line_rasterizer.
`timescale 1ns / 1ps

package mlr_pkg;

    // Codes on the input tuser bit
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH    = 4;
    localparam int CMDQ_PTR_BITS = 2;
    localparam int CMDQ_CNT_BITS = 3;

    // Octant: y-major flag and x-runs-backward flag
    typedef struct packed {
        logic neg;
        logic ymaj;
    } octant_t;

    // Control part of a classified command
    typedef struct packed {
        logic    is_start;
        octant_t oct;
    } cmd_ctl_t;

    // Back-end status, watched by the top-level checks
    typedef struct packed {
        logic busy;
        logic take;
        logic emit;
    } back_stat_t;

endpackage

@@ hdl/mlr_front.sv @@
// Front end: accepts input beats, swaps endpoints, works out spans,
// octant and initial decision value. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [4*COORD_BITS-1:0]   in_coords,   // start_x, start_y, end_x, end_y
    input  logic                      in_mode,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output mlr_pkg::cmd_ctl_t         cmd_ctl,
    output logic [COORD_BITS-1:0]     cmd_x,
    output logic [COORD_BITS-1:0]     cmd_y,
    output logic [COORD_BITS-1:0]     cmd_stop,
    output logic [COORD_BITS-1:0]     cmd_span_x,
    output logic [COORD_BITS-1:0]     cmd_span_y,
    output logic [COORD_BITS+1:0]     cmd_dec
);

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 2;

    logic [C-1:0] x1, y1, x2, y2;
    logic [C-1:0] xa, ya, xb, yb;
    logic         swap, neg, ymaj;
    logic [C-1:0] sx, sy;
    logic [DW-1:0] dec_init;

    logic                 vld_reg, vld_next;
    mlr_pkg::cmd_ctl_t    ctl_reg, ctl_next;
    logic [C-1:0]         x_reg, x_next, y_reg, y_next, stop_reg, stop_next;
    logic [C-1:0]         sx_reg, sx_next, sy_reg, sy_next;
    logic [DW-1:0]        dec_reg, dec_next;
    logic                 accept;

    assign x1 = in_coords[C-1:0];
    assign y1 = in_coords[2*C-1:C];
    assign x2 = in_coords[3*C-1:2*C];
    assign y2 = in_coords[4*C-1:3*C];

    // Classification: y never decreases along the line
    always_comb begin
        swap = (y2 < y1);
        xa   = swap ? x2 : x1;
        ya   = swap ? y2 : y1;
        xb   = swap ? x1 : x2;
        yb   = swap ? y1 : y2;
        neg  = (xb < xa);
        sx   = neg ? (xa - xb) : (xb - xa);
        sy   = yb - ya;
        ymaj = (sy > sx);          // ties stay x-major
        if (ymaj) begin
            dec_init = DW'(sx) - DW'(sy[C-1:1]);
        end else begin
            dec_init = DW'(sy) - DW'(sx[C-1:1]);
        end
    end

    assign s_axis_tready = !vld_reg || cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Holding register in front of the queue
    always_comb begin
        vld_next  = vld_reg;
        ctl_next  = ctl_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        stop_next = stop_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        dec_next  = dec_reg;
        if (accept) begin
            vld_next          = 1'b1;
            ctl_next.is_start = (in_mode == mlr_pkg::MODE_START);
            ctl_next.oct.neg  = neg;
            ctl_next.oct.ymaj = ymaj;
            x_next            = xa;
            y_next            = ya;
            stop_next         = ymaj ? yb : xb;
            sx_next           = sx;
            sy_next           = sy;
            dec_next          = dec_init;
        end else if (cmd_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg  <= ctl_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        stop_reg <= stop_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        dec_reg  <= dec_next;
    end

    assign cmd_valid  = vld_reg;
    assign cmd_ctl    = ctl_reg;
    assign cmd_x      = x_reg;
    assign cmd_y      = y_reg;
    assign cmd_stop   = stop_reg;
    assign cmd_span_x = sx_reg;
    assign cmd_span_y = sy_reg;
    assign cmd_dec    = dec_reg;

endmodule

@@ hdl/mlr_cmdq.sv @@
// Small first-in first-out queue of classified commands.
// Depth comes from mlr_pkg.
`timescale 1ns / 1ps

module mlr_cmdq #(
    parameter int DATA_BITS = 77
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int PB = mlr_pkg::CMDQ_PTR_BITS;
    localparam int CB = mlr_pkg::CMDQ_CNT_BITS;

    logic [DATA_BITS-1:0] slot_reg [mlr_pkg::CMDQ_DEPTH];
    logic [PB-1:0]        wp_reg, wp_next, rp_reg, rp_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic                 wr, rd;

    assign wr_ready = (cnt_reg != CB'(mlr_pkg::CMDQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rp_reg];

    // Pointer and fill-level update
    always_comb begin
        wp_next  = wr ? wp_reg + PB'(1) : wp_reg;
        rp_next  = rd ? rp_reg + PB'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (wr && !rd) begin
            cnt_next = cnt_reg + CB'(1);
        end else if (rd && !wr) begin
            cnt_next = cnt_reg - CB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/mlr_back.sv @@
// Back end: holds the line state, loads it on a start command, runs one midpoint
// step per step command while busy, drives the output register. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  mlr_pkg::cmd_ctl_t      cmd_ctl,
    input  logic [COORD_BITS-1:0]  cmd_x,
    input  logic [COORD_BITS-1:0]  cmd_y,
    input  logic [COORD_BITS-1:0]  cmd_stop,
    input  logic [COORD_BITS-1:0]  cmd_span_x,
    input  logic [COORD_BITS-1:0]  cmd_span_y,
    input  logic [COORD_BITS+1:0]  cmd_dec,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  out_x,
    output logic [COORD_BITS-1:0]  out_y,
    output logic                   out_last,
    output mlr_pkg::back_stat_t    stat
);

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 2;
    localparam logic [C-1:0] ONE = C'(1);

    logic [C-1:0]      cx_reg, cx_next, cy_reg, cy_next, stop_reg, stop_next;
    logic [C-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic [DW-1:0]     dec_reg, dec_next;
    mlr_pkg::octant_t  oct_reg, oct_next;
    logic              busy_reg, busy_next;
    logic              ov_reg, ov_next, ol_reg, ol_next;
    logic [C-1:0]      ox_reg, ox_next, oy_reg, oy_next;

    logic              out_free, produces, take, emit, dec_neg, fin;
    logic [C-1:0]      x_adv, y_inc, sx_x, sx_y;
    logic [DW-1:0]     step_dec;

    assign out_free  = !ov_reg || out_ready;
    assign produces  = cmd_ctl.is_start || busy_reg;
    assign take      = cmd_valid && (out_free || !produces);
    assign emit      = take && produces;
    assign cmd_ready = out_free || !produces;

    // One midpoint step from the held state
    always_comb begin
        dec_neg = dec_reg[DW-1];
        x_adv   = oct_reg.neg ? (cx_reg - ONE) : (cx_reg + ONE);
        y_inc   = cy_reg + ONE;
        if (oct_reg.ymaj) begin
            sx_y     = y_inc;
            sx_x     = dec_neg ? cx_reg : x_adv;
            step_dec = dec_reg + DW'(sx_reg) - (dec_neg ? '0 : DW'(sy_reg));
        end else begin
            sx_x     = x_adv;
            sx_y     = dec_neg ? cy_reg : y_inc;
            step_dec = dec_reg + DW'(sy_reg) - (dec_neg ? '0 : DW'(sx_reg));
        end
    end

    // State and output register update
    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        stop_next = stop_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        dec_next  = dec_reg;
        oct_next  = oct_reg;
        if (take && cmd_ctl.is_start) begin
            cx_next   = cmd_x;
            cy_next   = cmd_y;
            stop_next = cmd_stop;
            sx_next   = cmd_span_x;
            sy_next   = cmd_span_y;
            dec_next  = cmd_dec;
            oct_next  = cmd_ctl.oct;
        end else if (emit) begin
            cx_next  = sx_x;
            cy_next  = sx_y;
            dec_next = step_dec;
        end
        fin       = oct_next.ymaj ? (cy_next == stop_next) : (cx_next == stop_next);
        busy_next = emit ? !fin : busy_reg;

        ov_next = ov_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        ol_next = ol_reg;
        if (emit) begin
            ov_next = 1'b1;
            ox_next = cx_next;
            oy_next = cy_next;
            ol_next = fin;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            stop_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            dec_reg  <= '0;
            oct_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            stop_reg <= stop_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            dec_reg  <= dec_next;
            oct_reg  <= oct_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        ol_reg <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = ol_reg;

    assign stat.busy = busy_reg;
    assign stat.take = take;
    assign stat.emit = emit;

endmodule

@@ hdl/midpoint_line_rasterizer.sv @@
// Top level of the midpoint line rasteriser: front end, command queue, back end.
// Depends on mlr_pkg, mlr_front, mlr_cmdq and mlr_back.
`timescale 1ns / 1ps

// Draws lines with the midpoint algorithm. A beat with tuser = 0 starts a line
// between the two endpoints in tdata and gives its first pixel; each beat with
// tuser = 1 gives the next pixel, and tlast marks the final one. A step beat
// while no line is in progress gives no pixel; a start beat abandons any line
// in progress. Sustained rate is one beat in and one pixel out per clock while
// the output is not stalled: the back end's combinational step update (adds and
// one compare) sets this. A beat passes the front register, queue and output
// register in turn; the four-entry queue lets either side stall on its own.

module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y (lowest bits first), zero-padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: mode
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: pixel_x, pixel_y (lowest bits first), zero-padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                     m_axis_tlast
);

    localparam int C      = COORD_BITS;
    localparam int DW     = COORD_BITS + 2;
    localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int CTL_W  = $bits(mlr_pkg::cmd_ctl_t);
    localparam int QW     = CTL_W + 5*COORD_BITS + COORD_BITS + 2;

    logic                f_valid, f_ready;
    mlr_pkg::cmd_ctl_t   f_ctl, b_ctl;
    logic [C-1:0]        f_x, f_y, f_stop, f_sx, f_sy;
    logic [C-1:0]        b_x, b_y, b_stop, b_sx, b_sy;
    logic [DW-1:0]       f_dec, b_dec;
    logic [QW-1:0]       q_wr_data, q_rd_data;
    logic                q_rd_valid, q_rd_ready;
    logic [C-1:0]        px, py;
    mlr_pkg::back_stat_t b_stat;

    // Front end
    mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_coords     (s_axis_tdata[4*C-1:0]),
        .in_mode       (s_axis_tuser),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd_ctl       (f_ctl),
        .cmd_x         (f_x),
        .cmd_y         (f_y),
        .cmd_stop      (f_stop),
        .cmd_span_x    (f_sx),
        .cmd_span_y    (f_sy),
        .cmd_dec       (f_dec)
    );

    assign q_wr_data = {f_ctl, f_x, f_y, f_stop, f_sx, f_sy, f_dec};

    // Command queue
    mlr_cmdq #(.DATA_BITS(QW)) u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // Unpack the queue head
    assign b_ctl  = mlr_pkg::cmd_ctl_t'(q_rd_data[QW-1 -: CTL_W]);
    assign b_x    = q_rd_data[DW+5*C-1 -: C];
    assign b_y    = q_rd_data[DW+4*C-1 -: C];
    assign b_stop = q_rd_data[DW+3*C-1 -: C];
    assign b_sx   = q_rd_data[DW+2*C-1 -: C];
    assign b_sy   = q_rd_data[DW+C-1 -: C];
    assign b_dec  = q_rd_data[DW-1:0];

    // Back end
    mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_rd_valid),
        .cmd_ready  (q_rd_ready),
        .cmd_ctl    (b_ctl),
        .cmd_x      (b_x),
        .cmd_y      (b_y),
        .cmd_stop   (b_stop),
        .cmd_span_x (b_sx),
        .cmd_span_y (b_sy),
        .cmd_dec    (b_dec),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (px),
        .out_y      (py),
        .out_last   (m_axis_tlast),
        .stat       (b_stat)
    );

    assign m_axis_tdata = OUT_W'({py, px});

    // Checks on the back end's bookkeeping
    a_emit_needs_take: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.emit |-> b_stat.take)
        else $error("pixel emitted without consuming a command");

    a_idle_step_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_stat.take && !b_stat.emit) |=> !b_stat.busy)
        else $error("dropped step left the back end busy");

    a_last_means_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> !b_stat.busy)
        else $error("busy while the final pixel waits");

    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        f_ready || q_rd_valid)
        else $error("command queue both full and empty");

endmodule
